// ===== hw/rtl/gem_pkg.sv =====
`timescale 1ns / 1ps

package gem_pkg;

    // Field widths of the request and response beats
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 12;
    localparam int SIDE_W     = 2;
    localparam int POS_W      = 6;
    localparam int IN_WAVE_W  = 16;
    localparam int OUT_WAVE_W = 16;

    // Configuration register widths
    localparam int GSIZE_W    = 7;
    localparam int WEIGHT_W   = 9;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Effective side is at most 127, so a cell index fits in 14 bits
    localparam int CELL_IDX_W = 14;

    // Default sizing
    localparam int GRID_MAX_DEF  = 64;
    localparam int WAVE_BITS_DEF = 16;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Reset values of the configuration registers
    localparam logic [GSIZE_W-1:0]  GSIZE_RST  = 7'd64;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd128;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_MERGE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Edge sides
    localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_GSIZE  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_WEIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_REPLACE = 2'd0,
        MODE_ADD     = 2'd1,
        MODE_BLEND   = 2'd2,
        MODE_THRESH  = 2'd3
    } t_mode;

    // Classified command kinds
    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_MERGE = 2'd1,
        K_READ  = 2'd2,
        K_ERR   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [CELL_IDX_W-1:0]  idx;
        logic                   alive;
        logic [IN_WAVE_W-1:0]   wave;
    } t_task;

    typedef struct packed {
        t_mode                  mode;
        logic [WEIGHT_W-1:0]    weight;
    } t_merge_cfg;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } t_back_state;

endpackage

// ===== hw/rtl/gem_if.sv =====
`timescale 1ns / 1ps

// Request channel: one command per beat
interface gem_req_if;
    logic                            valid;
    logic                            ready;
    logic [gem_pkg::OP_W-1:0]        operation;
    logic [gem_pkg::ADDR_W-1:0]      cell_address;
    logic [gem_pkg::SIDE_W-1:0]      edge_side;
    logic [gem_pkg::POS_W-1:0]       edge_position;
    logic                            in_alive;
    logic [gem_pkg::IN_WAVE_W-1:0]   in_wave;

    modport source (
        output valid, operation, cell_address, edge_side, edge_position, in_alive, in_wave,
        input  ready
    );
    modport sink (
        input  valid, operation, cell_address, edge_side, edge_position, in_alive, in_wave,
        output ready
    );
endinterface

// Response channel: one result per beat
interface gem_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            out_alive;
    logic [gem_pkg::OUT_WAVE_W-1:0]  out_wave;
    logic [gem_pkg::ADDR_W-1:0]      out_address;
    logic                            status;

    modport source (
        output valid, out_alive, out_wave, out_address, status,
        input  ready
    );
    modport sink (
        input  valid, out_alive, out_wave, out_address, status,
        output ready
    );
endinterface

// ===== hw/rtl/gem_front.sv =====
`timescale 1ns / 1ps

module gem_front #(
    parameter int GRID_MAX = gem_pkg::GRID_MAX_DEF
) (
    gem_req_if.sink                          i_req,
    input  logic [gem_pkg::GSIZE_W-1:0]      i_grid_size,
    input  logic                             i_full,
    output logic                             o_push,
    output gem_pkg::t_task                   o_task
);

    localparam int SZ_W = gem_pkg::GSIZE_W;
    localparam int IW   = gem_pkg::CELL_IDX_W;

    logic [SZ_W-1:0] sz;
    logic [IW-1:0]   cells;
    logic [IW-1:0]   sz_x;
    logic [IW-1:0]   pos_x;
    logic [IW-1:0]   last_row;
    logic [IW-1:0]   row_base;
    logic [IW-1:0]   edge_idx;
    logic            addr_ok;
    logic            pos_ok;

    // Effective side: zero reads as one, clamp to the store size
    always_comb begin
        if (i_grid_size == '0) begin
            sz = SZ_W'(1);
        end else if (32'(i_grid_size) > GRID_MAX) begin
            sz = SZ_W'(GRID_MAX);
        end else begin
            sz = i_grid_size;
        end
    end

    assign sz_x     = IW'(sz);
    assign pos_x    = IW'(i_req.edge_position);
    assign cells    = sz_x * sz_x;
    assign last_row = (sz_x - IW'(1)) * sz_x;
    assign row_base = pos_x * sz_x;
    assign addr_ok  = IW'(i_req.cell_address) < cells;
    assign pos_ok   = IW'(i_req.edge_position) < sz_x;

    // Boundary cell for the chosen edge
    always_comb begin
        unique case (i_req.edge_side)
            gem_pkg::SIDE_TOP:    edge_idx = pos_x;
            gem_pkg::SIDE_BOTTOM: edge_idx = last_row + pos_x;
            gem_pkg::SIDE_LEFT:   edge_idx = row_base;
            default:              edge_idx = row_base + sz_x - IW'(1);
        endcase
    end

    // Classify the beat into a back-end command
    always_comb begin
        o_task.alive = i_req.in_alive;
        o_task.wave  = i_req.in_wave;
        o_task.idx   = IW'(i_req.cell_address);
        o_task.kind  = gem_pkg::K_ERR;
        unique case (i_req.operation)
            gem_pkg::OP_WRITE: begin
                if (addr_ok) o_task.kind = gem_pkg::K_WRITE;
            end
            gem_pkg::OP_READ: begin
                if (addr_ok) o_task.kind = gem_pkg::K_READ;
            end
            gem_pkg::OP_MERGE: begin
                o_task.idx = edge_idx;
                if (pos_ok) o_task.kind = gem_pkg::K_MERGE;
            end
            default: o_task.kind = gem_pkg::K_ERR;
        endcase
    end

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

endmodule

// ===== hw/rtl/gem_queue.sv =====
`timescale 1ns / 1ps

module gem_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gem_pkg::t_task   i_data,
    output logic             o_full,
    output logic             o_valid,
    output gem_pkg::t_task   o_data,
    input  logic             i_pop
);

    localparam int DEPTH = gem_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    gem_pkg::t_task  r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    // Storage, no reset on payload
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== hw/rtl/gem_back.sv =====
`timescale 1ns / 1ps

module gem_back #(
    parameter int GRID_MAX  = gem_pkg::GRID_MAX_DEF,
    parameter int WAVE_BITS = gem_pkg::WAVE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  gem_pkg::t_task       i_task,
    output logic                 o_pop,
    input  gem_pkg::t_merge_cfg  i_cfg,
    gem_rsp_if.source            o_rsp
);

    localparam int CELL_NUM = GRID_MAX * GRID_MAX;
    localparam int MEM_AW   = $clog2(CELL_NUM);
    localparam int PW       = WAVE_BITS + 10;
    localparam int WW       = gem_pkg::WEIGHT_W;

    // Cell store: alive bit on top, wave below
    logic [WAVE_BITS:0]              r_mem [CELL_NUM];
    logic [WAVE_BITS:0]              r_rd;
    gem_pkg::t_task                  r_task;
    gem_pkg::t_back_state            r_state;
    gem_pkg::t_back_state            n_state;

    logic                            r_out_valid;
    logic                            r_out_alive;
    logic [gem_pkg::OUT_WAVE_W-1:0]  r_out_wave;
    logic [gem_pkg::ADDR_W-1:0]      r_out_address;
    logic                            r_out_status;

    logic                            load;
    logic                            we;
    logic [WAVE_BITS-1:0]            v_wave;
    logic                            old_alive;
    logic [WAVE_BITS-1:0]            cur_wave;
    logic [WW-1:0]                   alpha;
    logic [WW-1:0]                   k_alpha;
    logic [PW-1:0]                   blend_sum;
    logic [WW:0]                     alive_sum;
    logic                            mrg_alive;
    logic [WAVE_BITS-1:0]            mrg_wave;
    logic                            res_alive;
    logic [WAVE_BITS-1:0]            res_wave;
    logic                            res_status;

    assign v_wave    = WAVE_BITS'(r_task.wave);
    assign old_alive = r_rd[WAVE_BITS];
    assign cur_wave  = r_rd[WAVE_BITS-1:0];

    // Blend weights, alpha saturates at one
    assign alpha   = (i_cfg.weight > gem_pkg::WEIGHT_ONE) ? gem_pkg::WEIGHT_ONE : i_cfg.weight;
    assign k_alpha = gem_pkg::WEIGHT_ONE - alpha;

    assign blend_sum = PW'(cur_wave) * PW'(k_alpha) + PW'(v_wave) * PW'(alpha);
    assign alive_sum = (old_alive ? (WW + 1)'(k_alpha) : '0)
                     + (r_task.alive ? (WW + 1)'(alpha) : '0);

    // Merge modes
    always_comb begin
        unique case (i_cfg.mode)
            gem_pkg::MODE_REPLACE: begin
                mrg_alive = r_task.alive;
                mrg_wave  = v_wave;
            end
            gem_pkg::MODE_ADD: begin
                mrg_alive = old_alive | r_task.alive;
                mrg_wave  = (v_wave > cur_wave) ? v_wave : cur_wave;
            end
            gem_pkg::MODE_BLEND: begin
                mrg_alive = alive_sum >= (WW + 1)'(128);
                mrg_wave  = blend_sum[WAVE_BITS+7:8];
            end
            default: begin
                mrg_alive = r_task.alive ? r_task.alive : old_alive;
                mrg_wave  = r_task.alive ? v_wave : cur_wave;
            end
        endcase
    end

    // Result per command kind
    always_comb begin
        res_alive  = 1'b0;
        res_wave   = '0;
        res_status = 1'b0;
        unique case (r_task.kind)
            gem_pkg::K_WRITE: begin
                res_alive = r_task.alive;
                res_wave  = v_wave;
            end
            gem_pkg::K_READ: begin
                res_alive = old_alive;
                res_wave  = cur_wave;
            end
            gem_pkg::K_MERGE: begin
                res_alive = mrg_alive;
                res_wave  = mrg_wave;
            end
            default: res_status = 1'b1;
        endcase
    end

    // Sequencer: fetch cell, then update and post result
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        we      = 1'b0;
        unique case (r_state)
            gem_pkg::BK_IDLE: begin
                if (i_valid && (!r_out_valid || o_rsp.ready)) begin
                    o_pop   = 1'b1;
                    n_state = gem_pkg::BK_EXEC;
                end
            end
            gem_pkg::BK_EXEC: begin
                load    = 1'b1;
                we      = (r_task.kind == gem_pkg::K_WRITE) || (r_task.kind == gem_pkg::K_MERGE);
                n_state = gem_pkg::BK_IDLE;
            end
            default: n_state = gem_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gem_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Cell store port: registered read, single write
    always_ff @(posedge i_clk) begin
        if (o_pop) r_rd <= r_mem[MEM_AW'(i_task.idx)];
        if (we) r_mem[MEM_AW'(r_task.idx)] <= {res_alive, res_wave};
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_task <= i_task;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_alive   <= res_alive;
            r_out_wave    <= gem_pkg::OUT_WAVE_W'(res_wave);
            r_out_address <= res_status ? '0 : gem_pkg::ADDR_W'(r_task.idx);
            r_out_status  <= res_status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_alive   = r_out_alive;
    assign o_rsp.out_wave    = r_out_wave;
    assign o_rsp.out_address = r_out_address;
    assign o_rsp.status      = r_out_status;

`ifndef SYNTHESIS
    a_exec_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gem_pkg::BK_EXEC |-> !r_out_valid)
        else $error("update cycle with output register still full");

    a_exec_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gem_pkg::BK_EXEC |=> r_out_valid)
        else $error("update cycle did not post a result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status |->
            !r_out_alive && r_out_wave == '0 && r_out_address == '0)
        else $error("error result carries nonzero fields");
`endif

endmodule

// ===== hw/rtl/grid_edge_merge_unit.sv =====
// A request beat passes the queue, the cell fetch and the update before its response is valid.
// The back end takes a new command only once it is through with the last one, set by the
// read-then-write of the single cell store port; a full output register also holds it.
// Reset (synchronous, active low) clears queue, sequencer, output valid and the
// registers to grid_size 64, merge_mode 0, blend_weight 128; cell store is not cleared.
`timescale 1ns / 1ps

module grid_edge_merge_unit #(
    parameter int GRID_MAX  = gem_pkg::GRID_MAX_DEF,
    parameter int WAVE_BITS = gem_pkg::WAVE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    gem_req_if.sink                      i_req,
    gem_rsp_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gem_pkg::PADDR_W-1:0]  paddr,
    input  logic [gem_pkg::PDATA_W-1:0]  pwdata,
    output logic [gem_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    logic [gem_pkg::GSIZE_W-1:0]   r_grid_size;
    gem_pkg::t_mode                r_merge_mode;
    logic [gem_pkg::WEIGHT_W-1:0]  r_blend_weight;
    logic                          cfg_wr;

    gem_pkg::t_task                push_task;
    gem_pkg::t_task                head_task;
    gem_pkg::t_merge_cfg           merge_cfg;
    logic                          push;
    logic                          pop;
    logic                          q_full;
    logic                          q_valid;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size    <= gem_pkg::GSIZE_RST;
            r_merge_mode   <= gem_pkg::MODE_REPLACE;
            r_blend_weight <= gem_pkg::WEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                gem_pkg::REG_GSIZE:  r_grid_size    <= pwdata[gem_pkg::GSIZE_W-1:0];
                gem_pkg::REG_MODE:   r_merge_mode   <= gem_pkg::t_mode'(pwdata[1:0]);
                gem_pkg::REG_WEIGHT: r_blend_weight <= pwdata[gem_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gem_pkg::REG_GSIZE:  prdata = gem_pkg::PDATA_W'(r_grid_size);
            gem_pkg::REG_MODE:   prdata = gem_pkg::PDATA_W'(r_merge_mode);
            gem_pkg::REG_WEIGHT: prdata = gem_pkg::PDATA_W'(r_blend_weight);
            default:             prdata = '0;
        endcase
    end

    assign merge_cfg.mode   = r_merge_mode;
    assign merge_cfg.weight = r_blend_weight;

    gem_front #(
        .GRID_MAX (GRID_MAX)
    ) u_front (
        .i_req       (i_req),
        .i_grid_size (r_grid_size),
        .i_full      (q_full),
        .o_push      (push),
        .o_task      (push_task)
    );

    gem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_task),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_task),
        .i_pop   (pop)
    );

    gem_back #(
        .GRID_MAX  (GRID_MAX),
        .WAVE_BITS (WAVE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_task  (head_task),
        .o_pop   (pop),
        .i_cfg   (merge_cfg),
        .o_rsp   (o_rsp)
    );

endmodule
